/* rtl/ttlc_pkg.sv */
// Shared constants and types for the TTL cache.
`timescale 1ns / 1ps
`default_nettype none
package ttlc_pkg;
  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int TAG_W = 64;
  localparam int RT_W = 3;
  localparam int VAL_W = 32;
  localparam int TIME_W = 32;
  localparam int EXP_W = 33;
  localparam int OCC_W = 5;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE = 1'b1;

  typedef enum logic [2:0] {
    ST_ABSENT = 3'd0,
    ST_EXPIRED = 3'd1,
    ST_HIT = 3'd2,
    ST_STORED = 3'd3,
    ST_EVICTED = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_VSCAN,
    S_WRITE,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

/* rtl/ttl_cache_earliest_expiry_evict_core.sv */
// TTL cache: one slot compared per cycle by a shared key/expiry compare unit.
// A lookup or store scans every slot (S_SCAN), then passes S_DECIDE and S_WRITE
// to a registered result in S_DONE; a store with records into a full table with a
// new key adds a second scan (S_VSCAN) for the earliest-expiring victim.
// One item at a time: in_ready is low from accept until the result is taken.
// Reset clears all valid bits and the hit, miss and occupancy counters; slot contents are not reset.
`timescale 1ns / 1ps
`default_nettype none
module ttl_cache_earliest_expiry_evict_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic operation,
  input  wire logic [ttlc_pkg::TAG_W-1:0] name_key,
  input  wire logic [ttlc_pkg::RT_W-1:0] record_type,
  input  wire logic [ttlc_pkg::TIME_W-1:0] now_seconds,
  input  wire logic [ttlc_pkg::VAL_W-1:0] value_handle,
  input  wire logic [ttlc_pkg::TIME_W-1:0] ttl_seconds,
  input  wire logic has_records,
  output logic out_valid,
  input  wire logic out_ready,
  output logic hit,
  output logic [ttlc_pkg::VAL_W-1:0] value_out,
  output logic [2:0] status,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  output logic [ttlc_pkg::OCC_W-1:0] occupancy
);
  import ttlc_pkg::*;

  state_t state, state_next;

  logic [ENTRIES-1:0] valid;
  logic [TAG_W-1:0] mem_tag [ENTRIES];
  logic [RT_W-1:0] mem_rt [ENTRIES];
  logic [VAL_W-1:0] mem_val [ENTRIES];
  logic [EXP_W-1:0] mem_exp [ENTRIES];

  // latched item
  logic op_r, has_r;
  logic [TAG_W-1:0] key_r;
  logic [RT_W-1:0] rt_r;
  logic [TIME_W-1:0] now_r, ttl_r;
  logic [VAL_W-1:0] val_r;

  logic [IDX_W:0] ptr;
  logic [IDX_W-1:0] ptr_idx;
  logic found, free_found, vic_found;
  logic [IDX_W-1:0] found_idx, free_idx, vic_idx;
  logic [EXP_W-1:0] vic_exp;
  logic [TAG_W-1:0] vic_tag;
  logic [RT_W-1:0] vic_rt;
  logic [CNT_W-1:0] count;
  logic [31:0] hits, misses;

  // registered slot read
  logic rd_v;
  logic [IDX_W-1:0] rd_idx;
  logic rd_valid;
  logic [TAG_W-1:0] rd_tag;
  logic [RT_W-1:0] rd_rt;
  logic [EXP_W-1:0] rd_exp;
  logic [VAL_W-1:0] found_val;
  logic [EXP_W-1:0] found_exp;

  logic wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic evict;

  assign ptr_idx = ptr[IDX_W-1:0];
  assign in_ready = (state == S_IDLE);

  logic rd_match, rd_before;
  always_comb begin
    rd_match = rd_valid && rd_tag == key_r && rd_rt == rt_r;
    if (rd_exp != vic_exp) rd_before = rd_exp < vic_exp;
    else if (rd_tag != vic_tag) rd_before = rd_tag < vic_tag;
    else rd_before = rd_rt < vic_rt;
  end

  logic scan_end;
  assign scan_end = (ptr == (IDX_W + 1)'(ENTRIES));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: if (scan_end && !rd_v) state_next = S_DECIDE;
      S_DECIDE: begin
        if (op_r == OP_STORE && has_r && !found && !free_found)
          state_next = S_VSCAN;
        else state_next = S_WRITE;
      end
      S_VSCAN: if (scan_end && !rd_v) state_next = S_WRITE;
      S_WRITE: state_next = S_DONE;
      S_DONE: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // memory read/write
  always_ff @(posedge clk) begin
    rd_idx <= ptr_idx;
    rd_tag <= mem_tag[ptr_idx];
    rd_rt <= mem_rt[ptr_idx];
    rd_exp <= mem_exp[ptr_idx];
    rd_valid <= valid[ptr_idx];
    found_val <= mem_val[found_idx];
    if (wr_en) begin
      mem_tag[wr_idx] <= key_r;
      mem_rt[wr_idx] <= rt_r;
      mem_val[wr_idx] <= val_r;
      mem_exp[wr_idx] <= EXP_W'(now_r) + EXP_W'(ttl_r);
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_idx = found ? found_idx : (free_found ? free_idx : vic_idx);
    if (state == S_WRITE && op_r == OP_STORE && has_r) wr_en = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_r <= operation;
      key_r <= name_key;
      rt_r <= record_type;
      now_r <= now_seconds;
      val_r <= value_handle;
      ttl_r <= ttl_seconds;
      has_r <= has_records;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hits <= '0;
      misses <= '0;
      count <= '0;
      ptr <= '0;
      rd_v <= 1'b0;
      found <= 1'b0;
      free_found <= 1'b0;
      vic_found <= 1'b0;
      evict <= 1'b0;
      out_valid <= 1'b0;
      hit <= 1'b0;
      value_out <= '0;
      status <= ST_ABSENT;
    end else begin
      case (state)
        S_IDLE: begin
          ptr <= '0;
          rd_v <= 1'b0;
          found <= 1'b0;
          free_found <= 1'b0;
          vic_found <= 1'b0;
          evict <= 1'b0;
        end
        S_SCAN, S_VSCAN: begin
          if (!scan_end) ptr <= ptr + 1'b1;
          // data read at this edge belongs to slot ptr while ptr is in range
          rd_v <= !scan_end;
          if (rd_v) begin
            if (state == S_SCAN) begin
              if (rd_match && !found) begin
                found <= 1'b1;
                found_idx <= rd_idx;
                found_exp <= rd_exp;
              end
              if (!rd_valid && !free_found) begin
                free_found <= 1'b1;
                free_idx <= rd_idx;
              end
            end else if (rd_valid && (!vic_found || rd_before)) begin
              vic_found <= 1'b1;
              vic_idx <= rd_idx;
              vic_exp <= rd_exp;
              vic_tag <= rd_tag;
              vic_rt <= rd_rt;
            end
          end
        end
        S_DECIDE: begin
          ptr <= '0;
          rd_v <= 1'b0;
          if (state_next == S_VSCAN) evict <= 1'b1;
        end
        S_WRITE: begin
          out_valid <= 1'b1;
          hit <= 1'b0;
          value_out <= '0;
          if (op_r == OP_LOOKUP) begin
            if (!found) begin
              status <= ST_ABSENT;
              if (misses != '1) misses <= misses + 1'b1;
            end else if (EXP_W'(now_r) >= found_exp) begin
              status <= ST_EXPIRED;
              valid[found_idx] <= 1'b0;
              count <= count - 1'b1;
              if (misses != '1) misses <= misses + 1'b1;
            end else begin
              status <= ST_HIT;
              hit <= 1'b1;
              value_out <= found_val;
              if (hits != '1) hits <= hits + 1'b1;
            end
          end else if (!has_r) begin
            status <= ST_IGNORED;
          end else begin
            status <= evict ? ST_EVICTED : ST_STORED;
            valid[wr_idx] <= 1'b1;
            if (!found && free_found) count <= count + 1'b1;
          end
        end
        S_DONE: if (out_ready) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  assign hit_total = hits;
  assign miss_total = misses;
  assign occupancy = OCC_W'(count);

`ifndef SYNTHESIS
  a_ready_out: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_count: assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(valid))) else $error("occupancy mismatch");
  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> status == ST_HIT) else $error("hit without hit status");
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    state == S_VSCAN |-> valid == '1) else $error("eviction scan on non-full table");
`endif
endmodule
`default_nettype wire
